FILE: sv/ssrs_pkg.sv
// Shared types and codes for the stepper speed ramp sequencer.
// No dependencies; used by ssrs_core and stepper_speed_ramp_sequencer.
`default_nettype none

package ssrs_pkg;

    localparam int SPEED_W = 18;
    localparam int TIMER_W = 24;
    localparam int CFG_W   = (SPEED_W > TIMER_W) ? SPEED_W : TIMER_W;
    localparam int CFG_IDX_W = 2;

    // opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_INIT  = 3'd1;
    localparam logic [2:0] OP_RUN   = 3'd2;
    localparam logic [2:0] OP_STOP  = 3'd3;
    localparam logic [2:0] OP_ESTOP = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_INIT = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    // sequence phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_DOWN  = 3'd1;
    localparam logic [2:0] PH_DWAIT = 3'd2;
    localparam logic [2:0] PH_SETUP = 3'd3;
    localparam logic [2:0] PH_UP    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWAIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP    = 2'd3;

    localparam logic [SPEED_W-1:0] ACCEL_RST    = SPEED_W'(100);
    localparam logic [TIMER_W-1:0] INTERVAL_RST = TIMER_W'(10000);
    localparam logic [TIMER_W-1:0] DWAIT_RST    = TIMER_W'(75000);
    localparam logic [TIMER_W-1:0] SETUP_RST    = TIMER_W'(5);

    typedef struct packed {
        logic [2:0]         opcode;
        logic               direction;
        logic [SPEED_W-1:0] target_speed;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SPEED_W-1:0] pulse_freq;
        logic               pulse_on;
        logic               driver_enable;
        logic               dir_out;
        logic [2:0]         phase;
    } rsp_t;

    typedef struct packed {
        logic [SPEED_W-1:0] accel_step_hz;
        logic [TIMER_W-1:0] ramp_interval_ticks;
        logic [TIMER_W-1:0] dir_change_wait_ticks;
        logic [TIMER_W-1:0] dir_setup_ticks;
    } cfg_t;

    typedef struct packed {
        logic               ready_flag;
        logic [SPEED_W-1:0] speed_now;
        logic               dir_now;
        logic [SPEED_W-1:0] speed_goal;
        logic               dir_goal;
        logic [2:0]         seq_phase;
        logic [TIMER_W-1:0] wait_count;
        logic               enable;
        logic               pulse;
        logic               stop_only;
    } seq_state_t;

endpackage

`default_nettype wire

FILE: sv/ssrs_core.sv
// Next-state and result logic for one request of the ramp sequencer.
// Depends on ssrs_pkg.
`default_nettype none

module ssrs_core (
    input  wire ssrs_pkg::cmd_t       cmd,
    input  wire ssrs_pkg::cfg_t       cfg,
    input  wire ssrs_pkg::seq_state_t st,
    output ssrs_pkg::seq_state_t      st_next,
    output ssrs_pkg::rsp_t            rsp
);

    logic [ssrs_pkg::SPEED_W-1:0] step;
    logic [ssrs_pkg::TIMER_W-1:0] wc_dec;
    logic                         busy;
    logic [1:0]                   status;
    ssrs_pkg::seq_state_t         nxt;

    function automatic ssrs_pkg::seq_state_t do_down(ssrs_pkg::seq_state_t s,
                                                     logic [ssrs_pkg::SPEED_W-1:0] stp,
                                                     ssrs_pkg::cfg_t c);
        ssrs_pkg::seq_state_t r;
        r = s;
        r.seq_phase  = ssrs_pkg::PH_DOWN;
        r.speed_now  = (s.speed_now > stp) ? s.speed_now - stp : '0;
        r.pulse      = (r.speed_now != '0);
        r.wait_count = c.ramp_interval_ticks;
        return r;
    endfunction

    function automatic ssrs_pkg::seq_state_t do_setup(ssrs_pkg::seq_state_t s,
                                                      ssrs_pkg::cfg_t c);
        ssrs_pkg::seq_state_t r;
        r = s;
        r.dir_now    = s.dir_goal;
        r.seq_phase  = ssrs_pkg::PH_SETUP;
        r.wait_count = c.dir_setup_ticks;
        return r;
    endfunction

    function automatic ssrs_pkg::seq_state_t do_up(ssrs_pkg::seq_state_t s,
                                                   logic [ssrs_pkg::SPEED_W-1:0] stp,
                                                   ssrs_pkg::cfg_t c);
        ssrs_pkg::seq_state_t         r;
        logic [ssrs_pkg::SPEED_W:0]   sum;
        r = s;
        r.enable = 1'b1;
        sum = {1'b0, s.speed_now} + {1'b0, stp};
        if (s.speed_now >= s.speed_goal)
        begin
            r.speed_now  = s.speed_goal;
            r.seq_phase  = ssrs_pkg::PH_IDLE;
            r.wait_count = '0;
        end
        else
        begin
            // one step up, clamped at the goal
            r.speed_now  = (sum > {1'b0, s.speed_goal}) ? s.speed_goal
                                                         : sum[ssrs_pkg::SPEED_W-1:0];
            r.seq_phase  = ssrs_pkg::PH_UP;
            r.wait_count = c.ramp_interval_ticks;
        end
        r.pulse = (r.speed_now != '0);
        return r;
    endfunction

    assign step   = (cfg.accel_step_hz == '0) ? ssrs_pkg::SPEED_W'(1) : cfg.accel_step_hz;
    assign busy   = (st.seq_phase != ssrs_pkg::PH_IDLE);
    assign wc_dec = (st.wait_count != '0) ? st.wait_count - ssrs_pkg::TIMER_W'(1)
                                          : st.wait_count;

    always_comb
    begin
        nxt    = st;
        status = ssrs_pkg::ST_OK;
        case (cmd.opcode)
            ssrs_pkg::OP_TICK:
            begin
                if (busy)
                begin
                    nxt.wait_count = wc_dec;
                    if (wc_dec == '0)
                    begin
                        case (st.seq_phase)
                            ssrs_pkg::PH_DOWN:
                            begin
                                if (st.speed_now != '0)
                                begin
                                    nxt = do_down(nxt, step, cfg);
                                end
                                else if (st.stop_only)
                                begin
                                    nxt.stop_only = 1'b0;
                                    nxt.seq_phase = ssrs_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    nxt.seq_phase  = ssrs_pkg::PH_DWAIT;
                                    nxt.wait_count = cfg.dir_change_wait_ticks;
                                end
                            end
                            ssrs_pkg::PH_DWAIT: nxt = do_setup(nxt, cfg);
                            ssrs_pkg::PH_SETUP: nxt = do_up(nxt, step, cfg);
                            ssrs_pkg::PH_UP:
                            begin
                                if (st.speed_now < st.speed_goal)
                                begin
                                    nxt = do_up(nxt, step, cfg);
                                end
                                else
                                begin
                                    nxt.speed_now = st.speed_goal;
                                    nxt.seq_phase = ssrs_pkg::PH_IDLE;
                                end
                            end
                            default: nxt.seq_phase = ssrs_pkg::PH_IDLE;
                        endcase
                    end
                end
            end
            ssrs_pkg::OP_INIT:
            begin
                if (busy)
                begin
                    status = ssrs_pkg::ST_BUSY;
                end
                else
                begin
                    nxt.enable     = 1'b0;
                    nxt.dir_now    = 1'b0;
                    nxt.ready_flag = 1'b1;
                end
            end
            ssrs_pkg::OP_RUN:
            begin
                if (!st.ready_flag)
                begin
                    status = ssrs_pkg::ST_NO_INIT;
                end
                else if (busy)
                begin
                    status = ssrs_pkg::ST_BUSY;
                end
                else
                begin
                    nxt.speed_goal = cmd.target_speed;
                    nxt.dir_goal   = cmd.direction;
                    nxt.stop_only  = 1'b0;
                    if (cmd.direction != st.dir_now && st.speed_now != '0)
                        nxt = do_down(nxt, step, cfg);
                    else if (cmd.direction != st.dir_now)
                        nxt = do_setup(nxt, cfg);
                    else
                        nxt = do_up(nxt, step, cfg);
                end
            end
            ssrs_pkg::OP_STOP:
            begin
                if (!st.ready_flag)
                begin
                    status = ssrs_pkg::ST_NO_INIT;
                end
                else if (busy)
                begin
                    status = ssrs_pkg::ST_BUSY;
                end
                else if (st.speed_now != '0)
                begin
                    nxt.stop_only = 1'b1;
                    nxt = do_down(nxt, step, cfg);
                end
            end
            ssrs_pkg::OP_ESTOP:
            begin
                // direction is kept
                nxt.pulse      = 1'b0;
                nxt.enable     = 1'b0;
                nxt.speed_now  = '0;
                nxt.seq_phase  = ssrs_pkg::PH_IDLE;
                nxt.wait_count = '0;
                nxt.stop_only  = 1'b0;
            end
            default: ;
        endcase
    end

    assign st_next           = nxt;
    assign rsp.status        = status;
    assign rsp.pulse_freq    = nxt.speed_now;
    assign rsp.pulse_on      = nxt.pulse;
    assign rsp.driver_enable = nxt.enable;
    assign rsp.dir_out       = nxt.dir_now;
    assign rsp.phase         = nxt.seq_phase;

endmodule

`default_nettype wire

FILE: sv/stepper_speed_ramp_sequencer.sv
// Stepper speed ramp sequencer: top level with state, config and result registers.
// Depends on ssrs_pkg and ssrs_core.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready, cmd): one request per tick, init, run,
//   controlled stop or emergency stop. Ticks are one microsecond apart.
//   rsp channel (rsp_valid/rsp_ready, rsp): exactly one response per request,
//   carrying command status and the driver lines after that request.
//   The response is registered: a request taken at edge N shows its response
//   after edge N. Throughput is one request per cycle while responses are
//   taken; the whole state update is a single pass through ssrs_core (one
//   add/subtract and compare on speed, one decrement on the wait counter).
//   cmd_ready is high while the response register is empty or being taken,
//   so a stalled receiver holds back requests after one response is buffered.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at the next edge
//   and belong only to idle periods.
//   Reset: not initialized, speed zero, forward, driver disabled, idle;
//   config returns to step 100 Hz, interval 10000, direction wait 75000,
//   setup 5 ticks.
`default_nettype none

module stepper_speed_ramp_sequencer (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cmd_valid,
    output logic                             cmd_ready,
    input  wire ssrs_pkg::cmd_t              cmd,
    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output ssrs_pkg::rsp_t                   rsp,
    input  wire                              cfg_we,
    input  wire [ssrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ssrs_pkg::CFG_W-1:0]        cfg_data
);

    ssrs_pkg::seq_state_t state_reg;
    ssrs_pkg::seq_state_t state_next;
    ssrs_pkg::cfg_t       cfg_reg;
    ssrs_pkg::rsp_t       rsp_reg;
    ssrs_pkg::rsp_t       rsp_next;
    logic                 rsp_valid_reg;
    logic                 accept;

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    ssrs_core u_core (
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .st      (state_reg),
        .st_next (state_next),
        .rsp     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_step_hz         <= ssrs_pkg::ACCEL_RST;
            cfg_reg.ramp_interval_ticks   <= ssrs_pkg::INTERVAL_RST;
            cfg_reg.dir_change_wait_ticks <= ssrs_pkg::DWAIT_RST;
            cfg_reg.dir_setup_ticks       <= ssrs_pkg::SETUP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssrs_pkg::CFG_ACCEL:
                    cfg_reg.accel_step_hz <= cfg_data[ssrs_pkg::SPEED_W-1:0];
                ssrs_pkg::CFG_INTERVAL:
                    cfg_reg.ramp_interval_ticks <= cfg_data[ssrs_pkg::TIMER_W-1:0];
                ssrs_pkg::CFG_DWAIT:
                    cfg_reg.dir_change_wait_ticks <= cfg_data[ssrs_pkg::TIMER_W-1:0];
                ssrs_pkg::CFG_SETUP:
                    cfg_reg.dir_setup_ticks <= cfg_data[ssrs_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // idle never leaves a wait pending
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq_phase == ssrs_pkg::PH_IDLE) |-> (state_reg.wait_count == '0))
        else $error("idle phase with nonzero wait count");

    // pulse generator runs exactly when speed is nonzero
    a_pulse_speed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pulse == (state_reg.speed_now != '0))
        else $error("pulse state disagrees with speed");

    // a sequence can only be under way after init
    a_seq_needs_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq_phase != ssrs_pkg::PH_IDLE) |-> state_reg.ready_flag)
        else $error("sequence active before init");

    // every accepted request yields a response next cycle
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request without response");
`endif

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for stepper_speed_ramp_sequencer: random requests, idle gaps, checks.
// Depends on ssrs_pkg and the sequencer RTL; keeps its own copy of the ramp state.

module testbench;

    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    ssrs_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    ssrs_pkg::rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [ssrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ssrs_pkg::CFG_W-1:0] cfg_data = '0;

    stepper_speed_ramp_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ramp settings as the block should hold them
    logic [ssrs_pkg::SPEED_W-1:0] accel_cfg = ssrs_pkg::ACCEL_RST;
    logic [ssrs_pkg::TIMER_W-1:0] interval_cfg = ssrs_pkg::INTERVAL_RST;
    logic [ssrs_pkg::TIMER_W-1:0] dwait_cfg = ssrs_pkg::DWAIT_RST;
    logic [ssrs_pkg::TIMER_W-1:0] setup_cfg = ssrs_pkg::SETUP_RST;

    // ramp state as the block should hold it
    logic                         armed = 1'b0;
    logic [ssrs_pkg::SPEED_W-1:0] cur_speed = '0;
    logic [ssrs_pkg::SPEED_W-1:0] goal_speed = '0;
    logic                         cur_dir = 1'b0;
    logic                         goal_dir = 1'b0;
    logic [2:0]                   seq_ph = ssrs_pkg::PH_IDLE;
    logic [ssrs_pkg::TIMER_W-1:0] wait_left = '0;
    logic                         drv_en = 1'b0;
    logic                         pulse_run = 1'b0;
    logic                         halt_only = 1'b0;

    ssrs_pkg::cmd_t cmd_backlog[$];
    ssrs_pkg::rsp_t due_resp[$];

    int fail_count = 0;
    int rsp_count = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    ssrs_pkg::rsp_t want;

    function automatic logic [ssrs_pkg::SPEED_W-1:0] step_hz();
        return (accel_cfg == '0) ? ssrs_pkg::SPEED_W'(1) : accel_cfg;
    endfunction

    function automatic void ramp_down_step();
        logic [ssrs_pkg::SPEED_W-1:0] s;
        s = step_hz();
        cur_speed = (cur_speed > s) ? cur_speed - s : '0;
        pulse_run = (cur_speed != '0);
        wait_left = interval_cfg;
    endfunction

    function automatic void start_setup();
        cur_dir = goal_dir;
        seq_ph = ssrs_pkg::PH_SETUP;
        wait_left = setup_cfg;
    endfunction

    function automatic void start_rampup();
        logic [ssrs_pkg::SPEED_W:0] sum;
        drv_en = 1'b1;
        if (cur_speed >= goal_speed)
        begin
            cur_speed = goal_speed;
            pulse_run = (cur_speed != '0);
            seq_ph = ssrs_pkg::PH_IDLE;
            wait_left = '0;
        end
        else
        begin
            sum = cur_speed + step_hz();
            cur_speed = (sum > goal_speed) ? goal_speed : sum[ssrs_pkg::SPEED_W-1:0];
            pulse_run = (cur_speed != '0);
            seq_ph = ssrs_pkg::PH_UP;
            wait_left = interval_cfg;
        end
    endfunction

    // applies one request to the ramp state and returns the lines it leaves
    function automatic ssrs_pkg::rsp_t ramp_response(ssrs_pkg::cmd_t c);
        ssrs_pkg::rsp_t r;
        logic busy;
        busy = (seq_ph != ssrs_pkg::PH_IDLE);
        r = '0;
        r.status = ssrs_pkg::ST_OK;
        case (c.opcode)
            ssrs_pkg::OP_TICK:
            begin
                if (busy)
                begin
                    if (wait_left != '0)
                        wait_left = wait_left - 1'b1;
                    if (wait_left == '0)
                    begin
                        case (seq_ph)
                            ssrs_pkg::PH_DOWN:
                            begin
                                if (cur_speed != '0)
                                    ramp_down_step();
                                else if (halt_only)
                                begin
                                    halt_only = 1'b0;
                                    seq_ph = ssrs_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    seq_ph = ssrs_pkg::PH_DWAIT;
                                    wait_left = dwait_cfg;
                                end
                            end
                            ssrs_pkg::PH_DWAIT: start_setup();
                            ssrs_pkg::PH_SETUP: start_rampup();
                            ssrs_pkg::PH_UP:
                            begin
                                if (cur_speed < goal_speed)
                                    start_rampup();
                                else
                                begin
                                    cur_speed = goal_speed;
                                    seq_ph = ssrs_pkg::PH_IDLE;
                                end
                            end
                            default: seq_ph = ssrs_pkg::PH_IDLE;
                        endcase
                    end
                end
            end
            ssrs_pkg::OP_INIT:
            begin
                if (busy)
                    r.status = ssrs_pkg::ST_BUSY;
                else
                begin
                    drv_en = 1'b0;
                    cur_dir = 1'b0;
                    armed = 1'b1;
                end
            end
            ssrs_pkg::OP_RUN:
            begin
                if (!armed)
                    r.status = ssrs_pkg::ST_NO_INIT;
                else if (busy)
                    r.status = ssrs_pkg::ST_BUSY;
                else
                begin
                    goal_speed = c.target_speed;
                    goal_dir = c.direction;
                    halt_only = 1'b0;
                    if (c.direction != cur_dir && cur_speed != '0)
                    begin
                        seq_ph = ssrs_pkg::PH_DOWN;
                        ramp_down_step();
                    end
                    else if (c.direction != cur_dir)
                        start_setup();
                    else
                        start_rampup();
                end
            end
            ssrs_pkg::OP_STOP:
            begin
                if (!armed)
                    r.status = ssrs_pkg::ST_NO_INIT;
                else if (busy)
                    r.status = ssrs_pkg::ST_BUSY;
                else if (cur_speed != '0)
                begin
                    halt_only = 1'b1;
                    seq_ph = ssrs_pkg::PH_DOWN;
                    ramp_down_step();
                end
            end
            ssrs_pkg::OP_ESTOP:
            begin
                pulse_run = 1'b0;
                drv_en = 1'b0;
                cur_speed = '0;
                seq_ph = ssrs_pkg::PH_IDLE;
                wait_left = '0;
                halt_only = 1'b0;
            end
            default: ;
        endcase
        r.pulse_freq = cur_speed;
        r.pulse_on = pulse_run;
        r.driver_enable = drv_en;
        r.dir_out = cur_dir;
        r.phase = seq_ph;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                due_resp.push_back(ramp_response(cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = !tx_calm;
                    send_gap = tx_calm ? 0 : $urandom_range(0, 5);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // response monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_resp.size() == 0)
                begin
                    $error("response with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_resp.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("pulse_freq", want.pulse_freq, rsp.pulse_freq);
                    check_field("pulse_on", want.pulse_on, rsp.pulse_on);
                    check_field("driver_enable", want.driver_enable, rsp.driver_enable);
                    check_field("dir_out", want.dir_out, rsp.dir_out);
                    check_field("phase", want.phase, rsp.phase);
                end
                rsp_count++;
                // one long back-pressure stretch so the input side stalls
                if (rsp_count == 150)
                    hold_left = 300;
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                recv_gap = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [2:0] op, input logic dir,
                             input logic [ssrs_pkg::SPEED_W-1:0] tgt);
        ssrs_pkg::cmd_t c;
        c.opcode = op;
        c.direction = dir;
        c.target_speed = tgt;
        cmd_backlog.push_back(c);
    endtask

    // targets mostly a few ramp steps away so ramps finish within the phase
    function automatic logic [ssrs_pkg::SPEED_W-1:0] pick_target();
        int unsigned r;
        int unsigned s;
        longint unsigned t;
        r = $urandom_range(0, 9);
        s = step_hz();
        t = longint'(s) * $urandom_range(1, 6) + $urandom_range(0, s - 1);
        case (r)
            0: return '1;
            1: return '0;
            2: return ssrs_pkg::SPEED_W'($urandom);
            default: return ((t >> ssrs_pkg::SPEED_W) != 0) ? '1 : t[ssrs_pkg::SPEED_W-1:0];
        endcase
    endfunction

    task automatic fill_phase(input int count);
        int made;
        int pick;
        int burst;
        logic [2:0] op;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                op = ssrs_pkg::OP_INIT;
            else if (pick < 26)
                op = ssrs_pkg::OP_RUN;
            else if (pick < 33)
                op = ssrs_pkg::OP_STOP;
            else if (pick < 36)
                op = ssrs_pkg::OP_ESTOP;
            else if (pick < 38)
                op = 3'($urandom_range(5, 7));
            else
                op = ssrs_pkg::OP_TICK;
            if (op == ssrs_pkg::OP_TICK)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    queue_cmd(ssrs_pkg::OP_TICK, 1'($urandom), ssrs_pkg::SPEED_W'($urandom));
                    made++;
                end
            end
            else
            begin
                queue_cmd(op, 1'($urandom),
                          (op == ssrs_pkg::OP_RUN) ? pick_target()
                                                   : ssrs_pkg::SPEED_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic write_reg(input logic [ssrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssrs_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ssrs_pkg::CFG_ACCEL:    accel_cfg = val[ssrs_pkg::SPEED_W-1:0];
            ssrs_pkg::CFG_INTERVAL: interval_cfg = val[ssrs_pkg::TIMER_W-1:0];
            ssrs_pkg::CFG_DWAIT:    dwait_cfg = val[ssrs_pkg::TIMER_W-1:0];
            ssrs_pkg::CFG_SETUP:    setup_cfg = val[ssrs_pkg::TIMER_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || due_resp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        logic [ssrs_pkg::SPEED_W-1:0] a;
        logic [ssrs_pkg::TIMER_W-1:0] iv;
        logic [ssrs_pkg::TIMER_W-1:0] dw;
        logic [ssrs_pkg::TIMER_W-1:0] su;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: before init, unused opcodes, busy rejects, zero target,
        // stop at zero speed, direction change from standstill
        queue_cmd(ssrs_pkg::OP_TICK, 1'b1, '1);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b0, ssrs_pkg::SPEED_W'(500));
        queue_cmd(ssrs_pkg::OP_STOP, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_ESTOP, 1'b1, '0);
        queue_cmd(3'd5, 1'b0, '1);
        queue_cmd(3'd6, 1'b1, '0);
        queue_cmd(3'd7, 1'b1, '1);
        queue_cmd(ssrs_pkg::OP_INIT, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_STOP, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b0, ssrs_pkg::SPEED_W'(250));
        queue_cmd(ssrs_pkg::OP_INIT, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b1, ssrs_pkg::SPEED_W'(40));
        queue_cmd(ssrs_pkg::OP_STOP, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_ESTOP, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b1, '1);
        repeat (5) queue_cmd(ssrs_pkg::OP_TICK, 1'b0, '0);
        queue_cmd(ssrs_pkg::OP_ESTOP, 1'b0, '1);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b1, '0);
        queue_cmd(ssrs_pkg::OP_INIT, 1'b1, '1);
        queue_cmd(ssrs_pkg::OP_RUN, 1'b0, '1);
        queue_cmd(ssrs_pkg::OP_ESTOP, 1'b0, '0);

        for (ph = 0; ph < 7; ph++)
        begin
            wait_drain();
            n = 62;
            case (ph)
                0:
                begin
                    a = '0;
                    iv = ssrs_pkg::TIMER_W'(1);
                    dw = '0;
                    su = '0;
                end
                1:
                begin
                    a = '1;
                    iv = ssrs_pkg::TIMER_W'(1);
                    dw = ssrs_pkg::TIMER_W'(1);
                    su = ssrs_pkg::TIMER_W'(1);
                end
                2:
                begin
                    // slowest settings: sequences only end by emergency stop
                    a = ssrs_pkg::SPEED_W'($urandom);
                    iv = '1;
                    dw = '1;
                    su = '1;
                    n = 40;
                end
                3:
                begin
                    a = ssrs_pkg::SPEED_W'(1);
                    iv = ssrs_pkg::TIMER_W'(2);
                    dw = ssrs_pkg::TIMER_W'(3);
                    su = ssrs_pkg::TIMER_W'(2);
                end
                default:
                begin
                    a = ssrs_pkg::SPEED_W'($urandom_range(1, 5000));
                    iv = ssrs_pkg::TIMER_W'($urandom_range(1, 4));
                    dw = ssrs_pkg::TIMER_W'($urandom_range(0, 4));
                    su = ssrs_pkg::TIMER_W'($urandom_range(0, 4));
                end
            endcase
            write_reg(ssrs_pkg::CFG_ACCEL, ssrs_pkg::CFG_W'(a));
            write_reg(ssrs_pkg::CFG_INTERVAL, ssrs_pkg::CFG_W'(iv));
            write_reg(ssrs_pkg::CFG_DWAIT, ssrs_pkg::CFG_W'(dw));
            write_reg(ssrs_pkg::CFG_SETUP, ssrs_pkg::CFG_W'(su));
            @(negedge clk);
            fill_phase(n);
            // leave the sequencer idle before the next settings change
            queue_cmd(ssrs_pkg::OP_ESTOP, 1'b0, '0);
        end

        wait_drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
